>>> rtl/uhid_pkg.sv
// shared types, request codes and descriptor tables of the hid dial device
package uhid_pkg;

	// input item opcodes
	typedef enum logic [1:0] {
		OP_SETUP     = 2'd0,
		OP_BUS_RESET = 2'd1,
		OP_REPORT    = 2'd2,
		OP_UNUSED    = 2'd3
	} opcode_t;

	// result kinds
	typedef enum logic [2:0] {
		KIND_DATA    = 3'd0,
		KIND_ACK     = 3'd1,
		KIND_STALL   = 3'd2,
		KIND_REPORT  = 3'd3,
		KIND_REFUSED = 3'd4
	} kind_t;

	// work handed from the decoder to the sequencer
	typedef enum logic [2:0] {
		CMD_DESC    = 3'd0,
		CMD_LIST    = 3'd1,
		CMD_REPORT  = 3'd2,
		CMD_ACK     = 3'd3,
		CMD_STALL   = 3'd4,
		CMD_REFUSED = 3'd5
	} cmd_t;

	// descriptor selectors
	typedef enum logic [1:0] {
		SEL_DEVICE = 2'd0,
		SEL_CONFIG = 2'd1,
		SEL_HID    = 2'd2,
		SEL_REPORT = 2'd3
	} sel_t;

	// standard and hid request codes
	localparam logic [7:0] RQ_GET_STATUS        = 8'h00;
	localparam logic [7:0] RQ_SET_ADDRESS       = 8'h05;
	localparam logic [7:0] RQ_GET_DESCRIPTOR    = 8'h06;
	localparam logic [7:0] RQ_GET_CONFIGURATION = 8'h08;
	localparam logic [7:0] RQ_SET_CONFIGURATION = 8'h09;
	localparam logic [7:0] RQ_HID_GET_REPORT    = 8'h01;
	localparam logic [7:0] RQ_HID_GET_IDLE      = 8'h02;
	localparam logic [7:0] RQ_HID_SET_IDLE      = 8'h0A;

	// bmRequestType values
	localparam logic [7:0] TYPE_STD_OUT   = 8'h00;
	localparam logic [7:0] TYPE_STD_IN    = 8'h80;
	localparam logic [7:0] TYPE_CLASS_IN  = 8'hA1;
	localparam logic [7:0] TYPE_CLASS_OUT = 8'h21;

	// wValue descriptor selectors
	localparam logic [15:0] DESC_DEVICE = 16'h0100;
	localparam logic [15:0] DESC_CONFIG = 16'h0200;
	localparam logic [15:0] DESC_HID    = 16'h2100;
	localparam logic [15:0] DESC_REPORT = 16'h2200;

	// configuration register indexes
	localparam logic [1:0] REG_VENDOR_ID       = 2'd0;
	localparam logic [1:0] REG_PRODUCT_ID      = 2'd1;
	localparam logic [1:0] REG_REPORT_ENDPOINT = 2'd2;

	localparam logic [2:0] REPORT_ENDPOINT_RESET = 3'd3;
	localparam logic [7:0] ENDPOINT_DIR_IN       = 8'h80;
	localparam logic [7:0] BUTTON_MASK           = 8'h0F;
	localparam int         LENGTH_LIMIT          = 255;

	// descriptor geometry
	localparam int MAX_ANSWER     = 41;
	localparam int DEV_LEN        = 18;
	localparam int CONF_LEN       = 34;
	localparam int HID_AT         = 18;
	localparam int HID_LEN        = 9;
	localparam int EP_ADDR_AT     = 29;
	localparam int REPORT_LEN     = 43;
	localparam int DEV_MAXPKT_AT  = 7;
	localparam int DEV_VID_LO_AT  = 8;
	localparam int DEV_VID_HI_AT  = 9;
	localparam int DEV_PID_LO_AT  = 10;
	localparam int DEV_PID_HI_AT  = 11;

	// answer caps after the result limit
	localparam int DEV_CAP    = (DEV_LEN > MAX_ANSWER) ? MAX_ANSWER : DEV_LEN;
	localparam int CONF_CAP   = (CONF_LEN > MAX_ANSWER) ? MAX_ANSWER : CONF_LEN;
	localparam int HID_CAP    = (HID_LEN > MAX_ANSWER) ? MAX_ANSWER : HID_LEN;
	localparam int REPORT_CAP = (REPORT_LEN > MAX_ANSWER) ? MAX_ANSWER : REPORT_LEN;

	localparam logic [7:0] DEV_ROM [DEV_LEN] = '{
		8'd18, 8'd1, 8'h00, 8'h02, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
		8'd0, 8'd0, 8'd0, 8'h00, 8'h01, 8'd0, 8'd0, 8'd0, 8'd1};

	localparam logic [7:0] CONF_ROM [CONF_LEN] = '{
		8'd9, 8'd2, 8'd34, 8'd0, 8'd1, 8'd1, 8'd0, 8'hC0, 8'd150,
		8'd9, 8'd4, 8'd0, 8'd0, 8'd1, 8'h03, 8'h00, 8'h00, 8'd0,
		8'd9, 8'h21, 8'h11, 8'h01, 8'd0, 8'd1, 8'h22, 8'd43, 8'd0,
		8'd7, 8'h05, 8'h80, 8'h03, 8'd8, 8'd0, 8'h01};

	localparam logic [7:0] REPORT_ROM [REPORT_LEN] = '{
		8'h05, 8'h01, 8'h09, 8'h04, 8'hA1, 8'h01,
		8'h05, 8'h09, 8'h19, 8'h01, 8'h29, 8'h04, 8'h15, 8'h00, 8'h25, 8'h01,
		8'h75, 8'h01, 8'h95, 8'h04, 8'h81, 8'h02,
		8'h75, 8'h01, 8'h95, 8'h04, 8'h81, 8'h01,
		8'h05, 8'h01, 8'h09, 8'h37, 8'h15, 8'h80, 8'h25, 8'h7F,
		8'h75, 8'h08, 8'h95, 8'h01, 8'h81, 8'h06,
		8'hC0};

	// configuration register file
	typedef struct packed {
		logic [15:0] vendor_id;
		logic [15:0] product_id;
		logic [2:0]  report_endpoint;
	} cfg_t;

	// one queued command
	typedef struct packed {
		cmd_t        cmd;
		sel_t        sel;
		logic [5:0]  count;
		logic [7:0]  b0;
		logic [7:0]  b1;
		logic [6:0]  addr;
		logic        addr_en;
	} entry_t;

	// descriptor byte lookup with the register fields patched in
	function automatic logic [7:0] desc_byte(sel_t sel, logic [5:0] idx, cfg_t cfg,
			logic [7:0] pkt_bytes);
		logic [6:0] j;
		logic [7:0] b;
		b = 8'd0;
		j = {1'b0, idx};
		case (sel)
			SEL_DEVICE: begin
				if (idx < 6'(DEV_LEN)) begin
					if (idx == 6'(DEV_MAXPKT_AT)) b = pkt_bytes;
					else if (idx == 6'(DEV_VID_LO_AT)) b = cfg.vendor_id[7:0];
					else if (idx == 6'(DEV_VID_HI_AT)) b = cfg.vendor_id[15:8];
					else if (idx == 6'(DEV_PID_LO_AT)) b = cfg.product_id[7:0];
					else if (idx == 6'(DEV_PID_HI_AT)) b = cfg.product_id[15:8];
					else b = DEV_ROM[idx[4:0]];
				end
			end
			SEL_CONFIG, SEL_HID: begin
				if (sel == SEL_HID) j = {1'b0, idx} + 7'(HID_AT);
				if (j < 7'(CONF_LEN)) begin
					if (j == 7'(EP_ADDR_AT)) b = ENDPOINT_DIR_IN | {5'd0, cfg.report_endpoint};
					else b = CONF_ROM[j[5:0]];
				end
			end
			SEL_REPORT: begin
				if (idx < 6'(REPORT_LEN)) b = REPORT_ROM[idx];
			end
			default: b = 8'd0;
		endcase
		return b;
	endfunction

endpackage

>>> rtl/uhid_front.sv
// request decoder: accepts items, keeps device state and queues commands
module uhid_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  logic [1:0]          opcode,
	input  logic [7:0]          request_type,
	input  logic [7:0]          request_code,
	input  logic [15:0]         request_value,
	input  logic [15:0]         request_index,
	input  logic [15:0]         host_max_bytes,
	input  logic [7:0]          buttons,
	input  logic signed [7:0]   dial_delta,
	input  logic                full,
	output logic                push,
	output uhid_pkg::entry_t    push_entry
);
	import uhid_pkg::*;

	logic [7:0] conf_q;
	logic [6:0] addr_q;
	logic       addr_en_q;

	logic [7:0] conf_d;
	logic [6:0] addr_d;
	logic       addr_en_d;
	logic       emit;
	logic       take;
	logic [5:0] cap;
	entry_t     e;

	assign req_ready = !full;
	assign take      = req_valid && req_ready;
	assign push      = take && emit;

	// classify the item and work out the state it leaves behind
	always_comb begin
		conf_d    = conf_q;
		addr_d    = addr_q;
		addr_en_d = addr_en_q;
		emit      = 1'b1;
		cap       = 6'd0;
		e.cmd     = CMD_STALL;
		e.sel     = SEL_DEVICE;
		e.count   = 6'd1;
		e.b0      = 8'd0;
		e.b1      = 8'd0;
		case (opcode_t'(opcode))
			OP_SETUP: begin
				if (request_code == RQ_GET_DESCRIPTOR) begin
					e.cmd = CMD_DESC;
					if (request_value == DESC_DEVICE) begin
						e.sel = SEL_DEVICE;
						cap   = 6'(DEV_CAP);
					end else if (request_value == DESC_CONFIG) begin
						e.sel = SEL_CONFIG;
						cap   = 6'(CONF_CAP);
					end else if (request_value == DESC_HID) begin
						e.sel = SEL_HID;
						cap   = 6'(HID_CAP);
					end else if (request_value == DESC_REPORT) begin
						e.sel = SEL_REPORT;
						cap   = 6'(REPORT_CAP);
					end else begin
						e.cmd = CMD_STALL;
					end
					if (e.cmd == CMD_DESC) begin
						// every cap is below the 255 byte limit
						e.count = (host_max_bytes < 16'(cap)) ? host_max_bytes[5:0] : cap;
						emit    = (e.count != 6'd0);
					end
				end else if (request_code == RQ_SET_CONFIGURATION
						&& request_type == TYPE_STD_OUT) begin
					conf_d = request_value[7:0];
					e.cmd  = CMD_ACK;
				end else if (request_code == RQ_SET_ADDRESS) begin
					addr_d    = request_value[6:0];
					addr_en_d = 1'b1;
					e.cmd     = CMD_ACK;
				end else if (request_code == RQ_GET_CONFIGURATION
						&& request_type == TYPE_STD_IN) begin
					e.cmd = CMD_LIST;
					e.b0  = conf_q;
				end else if (request_code == RQ_GET_STATUS) begin
					e.cmd   = CMD_LIST;
					e.count = 6'd2;
				end else if (request_index == 16'd0 && request_type == TYPE_CLASS_IN
						&& request_code == RQ_HID_GET_REPORT) begin
					e.cmd   = CMD_LIST;
					e.count = 6'd2;
				end else if (request_index == 16'd0 && request_type == TYPE_CLASS_IN
						&& request_code == RQ_HID_GET_IDLE) begin
					e.cmd = CMD_LIST;
				end else if (request_index == 16'd0 && request_type == TYPE_CLASS_OUT
						&& request_code == RQ_HID_SET_IDLE) begin
					e.cmd = CMD_ACK;
				end
			end
			OP_BUS_RESET: begin
				conf_d = 8'd0;
				emit   = 1'b0;
			end
			OP_REPORT: begin
				if (conf_q == 8'd0) begin
					e.cmd = CMD_REFUSED;
				end else begin
					e.cmd   = CMD_REPORT;
					e.count = 6'd2;
					e.b0    = buttons & BUTTON_MASK;
					e.b1    = dial_delta;
				end
			end
			default: emit = 1'b0;
		endcase
		e.addr    = addr_d;
		e.addr_en = addr_en_d;
	end

	assign push_entry = e;

	// device state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			conf_q    <= 8'd0;
			addr_q    <= 7'd0;
			addr_en_q <= 1'b0;
		end else if (take) begin
			conf_q    <= conf_d;
			addr_q    <= addr_d;
			addr_en_q <= addr_en_d;
		end
	end

endmodule

>>> rtl/uhid_queue.sv
// command queue between the decoder and the result sequencer
module uhid_queue #(
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  uhid_pkg::entry_t push_entry,
	output logic             full,
	input  logic             pop,
	output uhid_pkg::entry_t pop_entry,
	output logic             empty
);
	import uhid_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	entry_t        mem [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full      = (count_q == CW'(DEPTH));
	assign empty     = (count_q == '0);
	assign pop_entry = mem[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) mem[wr_ptr_q] <= push_entry;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)      count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

endmodule

>>> rtl/uhid_back.sv
// result sequencer: turns queued commands into result bytes, one per cycle while res_ready allows
module uhid_back #(
	parameter int PACKET_BYTES = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  uhid_pkg::cfg_t   cfg,
	input  logic             empty,
	input  uhid_pkg::entry_t pop_entry,
	output logic             pop,
	output logic             res_valid,
	input  logic             res_ready,
	output logic [2:0]       kind,
	output logic [7:0]       data_byte,
	output logic             packet_end,
	output logic             last,
	output logic [6:0]       device_address,
	output logic             address_enabled
);
	import uhid_pkg::*;

	localparam int PW = $clog2(PACKET_BYTES);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} state_t;

	state_t        state_q;
	entry_t        cur_q;
	logic [5:0]    idx_q;
	logic [PW-1:0] pkt_q;
	logic          res_valid_q;
	kind_t         kind_q;
	logic [7:0]    byte_q;
	logic          pend_q;
	logic          last_q;
	logic [6:0]    addr_q;
	logic          addr_en_q;

	logic          step;
	logic          fin;
	logic          pkt_full;
	kind_t         r_kind;
	logic [7:0]    r_byte;
	logic          r_pend;

	assign pop      = (state_q == ST_IDLE) && !empty;
	assign step     = (state_q == ST_RUN) && (!res_valid_q || res_ready);
	assign fin      = (idx_q == cur_q.count - 6'd1);
	assign pkt_full = (pkt_q == PW'(PACKET_BYTES - 1));

	// result of the current byte position
	always_comb begin
		r_kind = KIND_STALL;
		r_byte = 8'd0;
		r_pend = 1'b0;
		case (cur_q.cmd)
			CMD_DESC: begin
				r_kind = KIND_DATA;
				r_byte = desc_byte(cur_q.sel, idx_q, cfg, 8'(PACKET_BYTES));
				r_pend = fin || pkt_full;
			end
			CMD_LIST: begin
				r_kind = KIND_DATA;
				r_byte = (idx_q == 6'd0) ? cur_q.b0 : cur_q.b1;
				r_pend = fin || pkt_full;
			end
			CMD_REPORT: begin
				r_kind = KIND_REPORT;
				r_byte = (idx_q == 6'd0) ? cur_q.b0 : cur_q.b1;
				r_pend = fin;
			end
			CMD_ACK:     r_kind = KIND_ACK;
			CMD_REFUSED: r_kind = KIND_REFUSED;
			default:     r_kind = KIND_STALL;
		endcase
	end

	// sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: if (pop) state_q <= ST_RUN;
				ST_RUN:  if (step && fin) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
			if (step)           res_valid_q <= 1'b1;
			else if (res_ready) res_valid_q <= 1'b0;
		end
	end

	// command and byte position
	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= pop_entry;
			idx_q <= 6'd0;
			pkt_q <= '0;
		end else if (step) begin
			idx_q <= idx_q + 6'd1;
			pkt_q <= pkt_full ? '0 : pkt_q + 1'b1;
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (step) begin
			kind_q    <= r_kind;
			byte_q    <= r_byte;
			pend_q    <= r_pend;
			last_q    <= fin;
			addr_q    <= cur_q.addr;
			addr_en_q <= cur_q.addr_en;
		end
	end

	assign res_valid       = res_valid_q;
	assign kind            = kind_q;
	assign data_byte       = byte_q;
	assign packet_end      = pend_q;
	assign last            = last_q;
	assign device_address  = addr_q;
	assign address_enabled = addr_en_q;

endmodule

>>> rtl/usb_hid_control_request_handler_core.sv
// USB HID dial device core: endpoint 0 requests, bus reset and interrupt reports.
// A decoder takes one item per cycle while the command queue has room, updates the
// device state and queues a command; a sequencer then emits the results at one per
// cycle from its output register while res_ready allows. For each request the
// sequencer first loads the command from the queue and then produces its results
// in turn (up to 41 for a descriptor answer), so the sequencer sets the sustained
// rate. Items that give no result (bus end of reset, an empty descriptor answer)
// only pass the decoder. The queue holds QUEUE_DEPTH commands; no clearing pass is
// needed after reset.
module usb_hid_control_request_handler_core #(
	parameter int CONTROL_PACKET_BYTES = 32,
	parameter int QUEUE_DEPTH          = 2
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [15:0]       cfg_data,
	input  logic              req_valid,
	output logic              req_ready,
	input  logic [1:0]        opcode,
	input  logic [7:0]        request_type,
	input  logic [7:0]        request_code,
	input  logic [15:0]       request_value,
	input  logic [15:0]       request_index,
	input  logic [15:0]       host_max_bytes,
	input  logic [7:0]        buttons,
	input  logic signed [7:0] dial_delta,
	output logic              res_valid,
	input  logic              res_ready,
	output logic [2:0]        kind,
	output logic [7:0]        data_byte,
	output logic              packet_end,
	output logic              last,
	output logic [6:0]        device_address,
	output logic              address_enabled
);
	import uhid_pkg::*;

	cfg_t   cfg_q;
	entry_t push_entry;
	entry_t pop_entry;
	logic   push;
	logic   pop;
	logic   full;
	logic   empty;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.vendor_id       <= 16'd0;
			cfg_q.product_id      <= 16'd0;
			cfg_q.report_endpoint <= REPORT_ENDPOINT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_VENDOR_ID:       cfg_q.vendor_id       <= cfg_data;
				REG_PRODUCT_ID:      cfg_q.product_id      <= cfg_data;
				REG_REPORT_ENDPOINT: cfg_q.report_endpoint <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	uhid_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.req_valid      (req_valid),
		.req_ready      (req_ready),
		.opcode         (opcode),
		.request_type   (request_type),
		.request_code   (request_code),
		.request_value  (request_value),
		.request_index  (request_index),
		.host_max_bytes (host_max_bytes),
		.buttons        (buttons),
		.dial_delta     (dial_delta),
		.full           (full),
		.push           (push),
		.push_entry     (push_entry)
	);

	uhid_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (full),
		.pop        (pop),
		.pop_entry  (pop_entry),
		.empty      (empty)
	);

	uhid_back #(
		.PACKET_BYTES (CONTROL_PACKET_BYTES)
	) u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg             (cfg_q),
		.empty           (empty),
		.pop_entry       (pop_entry),
		.pop             (pop),
		.res_valid       (res_valid),
		.res_ready       (res_ready),
		.kind            (kind),
		.data_byte       (data_byte),
		.packet_end      (packet_end),
		.last            (last),
		.device_address  (device_address),
		.address_enabled (address_enabled)
	);

endmodule

>>> rtl/uhid_checker.sv
// port level checks of the hid device core and their bind
module uhid_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       res_valid,
	input logic       res_ready,
	input logic [2:0] kind,
	input logic [7:0] data_byte,
	input logic       packet_end,
	input logic       last,
	input logic [6:0] device_address,
	input logic       address_enabled
);
	import uhid_pkg::*;

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(kind) && $stable(data_byte)
			&& $stable(packet_end) && $stable(last) && $stable(device_address)
			&& $stable(address_enabled))
		else $error("stalled result changed");

	// single results carry no byte and close their item
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (kind == KIND_ACK || kind == KIND_STALL || kind == KIND_REFUSED)
			|-> data_byte == 8'd0 && !packet_end && last)
		else $error("single result malformed");

	// report bytes end their packet only on the last byte
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && kind == KIND_REPORT |-> packet_end == last)
		else $error("report packet end wrong");

	// the second report byte follows the first at once
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_ready && kind == KIND_REPORT && !last
			|=> res_valid && kind == KIND_REPORT && last)
		else $error("report second byte missing");

endmodule

bind usb_hid_control_request_handler_core uhid_checker u_checker (.*);

>>> dv/testbench.sv
// self-checking testbench for the usb hid dial request handler core
`timescale 1ns / 1ps

module testbench;
	import uhid_pkg::*;

	localparam int PACKET_BYTES    = 32;
	localparam int ANSWER_CAP      = 41;
	localparam int DEVICE_LEN      = 18;
	localparam int CONFIG_LEN      = 34;
	localparam int HID_START       = 18;
	localparam int HID_DESC_LEN    = 9;
	localparam int ENDPOINT_AT     = 29;
	localparam int RDESC_LEN       = 43;
	localparam int SETTLE_CYCLES   = 16;
	localparam int HOLD_CYCLES     = 200;
	localparam int WATCHDOG_LIMIT  = 2000;
	localparam int PRINT_LIMIT     = 40;

	// descriptor contents the host should read back
	localparam logic [7:0] DEVICE_BYTES [DEVICE_LEN] = '{
		8'd18, 8'd1, 8'h00, 8'h02, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0,
		8'd0, 8'd0, 8'd0, 8'h00, 8'h01, 8'd0, 8'd0, 8'd0, 8'd1};

	localparam logic [7:0] CONFIG_BYTES [CONFIG_LEN] = '{
		8'd9, 8'd2, 8'd34, 8'd0, 8'd1, 8'd1, 8'd0, 8'hC0, 8'd150,
		8'd9, 8'd4, 8'd0, 8'd0, 8'd1, 8'h03, 8'h00, 8'h00, 8'd0,
		8'd9, 8'h21, 8'h11, 8'h01, 8'd0, 8'd1, 8'h22, 8'd43, 8'd0,
		8'd7, 8'h05, 8'h80, 8'h03, 8'd8, 8'd0, 8'h01};

	localparam logic [7:0] RDESC_BYTES [RDESC_LEN] = '{
		8'h05, 8'h01, 8'h09, 8'h04, 8'hA1, 8'h01,
		8'h05, 8'h09, 8'h19, 8'h01, 8'h29, 8'h04, 8'h15, 8'h00, 8'h25, 8'h01,
		8'h75, 8'h01, 8'h95, 8'h04, 8'h81, 8'h02,
		8'h75, 8'h01, 8'h95, 8'h04, 8'h81, 8'h01,
		8'h05, 8'h01, 8'h09, 8'h37, 8'h15, 8'h80, 8'h25, 8'h7F,
		8'h75, 8'h08, 8'h95, 8'h01, 8'h81, 8'h06,
		8'hC0};

	// one request item; typed rows carry their single expected result kind
	typedef struct packed {
		opcode_t     op;
		logic [7:0]  rtype;
		logic [7:0]  rcode;
		logic [15:0] rvalue;
		logic [15:0] rindex;
		logic [15:0] rlength;
		logic [7:0]  btn;
		logic [7:0]  dial;
		logic        typed;
		kind_t       t_kind;
	} item_t;

	// one expected device answer
	typedef struct packed {
		kind_t      kind;
		logic [7:0] data;
		logic       pend;
		logic       fin;
		logic [6:0] addr;
		logic       aen;
	} answer_t;

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [1:0]        cfg_index;
	logic [15:0]       cfg_data;
	logic              req_valid;
	logic              req_ready;
	logic [1:0]        opcode;
	logic [7:0]        request_type;
	logic [7:0]        request_code;
	logic [15:0]       request_value;
	logic [15:0]       request_index;
	logic [15:0]       host_max_bytes;
	logic [7:0]        buttons;
	logic signed [7:0] dial_delta;
	logic              res_valid;
	logic              res_ready;
	logic [2:0]        kind;
	logic [7:0]        data_byte;
	logic              packet_end;
	logic              last;
	logic [6:0]        device_address;
	logic              address_enabled;

	item_t   cur_item;
	answer_t pending_answers [$];
	answer_t fresh_answers [$];

	// device state as the host sees it
	logic [15:0] vendor_reg = 16'd0;
	logic [15:0] product_reg = 16'd0;
	logic [2:0]  endpoint_reg = REPORT_ENDPOINT_RESET;
	logic [7:0]  config_value = 8'd0;
	logic [6:0]  dev_addr = 7'd0;
	logic        dev_addr_en = 1'b0;

	int  mismatches = 0;
	int  idle_cycles = 0;
	int  hold_requests = 0;
	int  hold_served = 0;
	int  hold_left = 0;
	bit  quiet = 1'b0;

	// directed requests: every request, the field extremes and the corner cases
	item_t directed_rows [25] = '{
		'{OP_REPORT, 8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000, 8'hFF, 8'h80, 1'b1, KIND_REFUSED},
		'{OP_SETUP, TYPE_STD_IN, RQ_GET_DESCRIPTOR, DESC_DEVICE, 16'h0000, 16'hFFFF,
			8'h00, 8'h00, 1'b0, KIND_DATA},
		'{OP_SETUP, TYPE_STD_IN, RQ_GET_DESCRIPTOR, DESC_CONFIG, 16'h0000, 16'd255,
			8'h00, 8'h00, 1'b0, KIND_DATA},
		'{OP_SETUP, TYPE_STD_IN, RQ_GET_DESCRIPTOR, DESC_HID, 16'h0000, 16'd9,
			8'h00, 8'h00, 1'b0, KIND_DATA},
		'{OP_SETUP, TYPE_STD_IN, RQ_GET_DESCRIPTOR, DESC_REPORT, 16'hFFFF, 16'hFFFF,
			8'h00, 8'h00, 1'b0, KIND_DATA},
		'{OP_SETUP, TYPE_STD_IN, RQ_GET_DESCRIPTOR, DESC_REPORT, 16'h0000, 16'h0000,
			8'h00, 8'h00, 1'b0, KIND_DATA},
		'{OP_SETUP, TYPE_STD_IN, RQ_GET_DESCRIPTOR, DESC_DEVICE, 16'h0000, 16'd1,
			8'h00, 8'h00, 1'b0, KIND_DATA},
		'{OP_SETUP, TYPE_STD_IN, RQ_GET_DESCRIPTOR, 16'h0300, 16'h0000, 16'd64,
			8'h00, 8'h00, 1'b1, KIND_STALL},
		'{OP_SETUP, 8'hFF, RQ_SET_ADDRESS, 16'hFFFF, 16'hFFFF, 16'h0000,
			8'h00, 8'h00, 1'b1, KIND_ACK},
		'{OP_SETUP, TYPE_STD_IN, RQ_SET_CONFIGURATION, 16'h0001, 16'h0000, 16'h0000,
			8'h00, 8'h00, 1'b1, KIND_STALL},
		'{OP_SETUP, TYPE_STD_OUT, RQ_SET_CONFIGURATION, 16'h0001, 16'h0000, 16'h0000,
			8'h00, 8'h00, 1'b1, KIND_ACK},
		'{OP_SETUP, TYPE_STD_IN, RQ_GET_CONFIGURATION, 16'h0000, 16'h0000, 16'd1,
			8'h00, 8'h00, 1'b0, KIND_DATA},
		'{OP_SETUP, TYPE_STD_OUT, RQ_GET_CONFIGURATION, 16'h0000, 16'h0000, 16'd1,
			8'h00, 8'h00, 1'b1, KIND_STALL},
		'{OP_SETUP, 8'hFF, RQ_GET_STATUS, 16'hFFFF, 16'hFFFF, 16'h0000,
			8'h00, 8'h00, 1'b0, KIND_DATA},
		'{OP_SETUP, TYPE_CLASS_IN, RQ_HID_GET_REPORT, 16'h0100, 16'h0000, 16'd2,
			8'h00, 8'h00, 1'b0, KIND_DATA},
		'{OP_SETUP, TYPE_CLASS_IN, RQ_HID_GET_REPORT, 16'h0100, 16'h0001, 16'd2,
			8'h00, 8'h00, 1'b1, KIND_STALL},
		'{OP_SETUP, TYPE_CLASS_IN, RQ_HID_GET_IDLE, 16'h0000, 16'h0000, 16'd1,
			8'h00, 8'h00, 1'b0, KIND_DATA},
		'{OP_SETUP, TYPE_CLASS_OUT, RQ_HID_SET_IDLE, 16'h0000, 16'h0000, 16'h0000,
			8'h00, 8'h00, 1'b1, KIND_ACK},
		'{OP_SETUP, TYPE_CLASS_OUT, RQ_HID_SET_IDLE, 16'h0000, 16'h8000, 16'h0000,
			8'h00, 8'h00, 1'b1, KIND_STALL},
		'{OP_SETUP, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'h00, 8'h00, 1'b1, KIND_STALL},
		'{OP_REPORT, 8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000, 8'hFF, 8'h7F, 1'b0, KIND_DATA},
		'{OP_REPORT, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'h00, 8'h80, 1'b0, KIND_DATA},
		'{OP_UNUSED, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 1'b0, KIND_DATA},
		'{OP_BUS_RESET, 8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000, 8'h00, 8'h00, 1'b0, KIND_DATA},
		'{OP_REPORT, 8'h00, 8'h00, 16'h0000, 16'h0000, 16'h0000, 8'h5A, 8'hA5, 1'b1, KIND_REFUSED}
	};

	usb_hid_control_request_handler_core DUT (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.req_valid       (req_valid),
		.req_ready       (req_ready),
		.opcode          (opcode),
		.request_type    (request_type),
		.request_code    (request_code),
		.request_value   (request_value),
		.request_index   (request_index),
		.host_max_bytes  (host_max_bytes),
		.buttons         (buttons),
		.dial_delta      (dial_delta),
		.res_valid       (res_valid),
		.res_ready       (res_ready),
		.kind            (kind),
		.data_byte       (data_byte),
		.packet_end      (packet_end),
		.last            (last),
		.device_address  (device_address),
		.address_enabled (address_enabled)
	);

	// 100 MHz clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	task automatic report_mismatch(input string field, input int unsigned got,
			input int unsigned want);
		if (mismatches < PRINT_LIMIT)
			$display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $time, field, got, want);
		mismatches++;
	endtask

	function automatic logic [7:0] descriptor_byte(int sel, int i);
		int j;
		j = (sel == 2) ? i + HID_START : i;
		case (sel)
			0: begin
				if (i == 7) return 8'(PACKET_BYTES);
				if (i == 8) return vendor_reg[7:0];
				if (i == 9) return vendor_reg[15:8];
				if (i == 10) return product_reg[7:0];
				if (i == 11) return product_reg[15:8];
				return DEVICE_BYTES[i];
			end
			1, 2: begin
				if (j == ENDPOINT_AT) return ENDPOINT_DIR_IN | {5'd0, endpoint_reg};
				return CONFIG_BYTES[j];
			end
			default: return RDESC_BYTES[i];
		endcase
	endfunction

	function automatic void emit(kind_t k, logic [7:0] b, logic p);
		fresh_answers.push_back('{k, b, p, 1'b0, 7'd0, 1'b0});
	endfunction

	// device behavior: update state, queue the answers of one transfer
	function automatic void predict_answer(item_t it);
		int sel;
		int dlen;
		int n;
		fresh_answers.delete();
		sel = -1;
		dlen = 0;
		case (it.op)
			OP_SETUP: begin
				if (it.rcode == RQ_GET_DESCRIPTOR) begin
					case (it.rvalue)
						DESC_DEVICE: begin sel = 0; dlen = DEVICE_LEN; end
						DESC_CONFIG: begin sel = 1; dlen = CONFIG_LEN; end
						DESC_HID:    begin sel = 2; dlen = HID_DESC_LEN; end
						DESC_REPORT: begin sel = 3; dlen = RDESC_LEN; end
						default:     sel = -1;
					endcase
					if (sel < 0) begin
						emit(KIND_STALL, 8'd0, 1'b0);
					end else begin
						n = it.rlength;
						if (n > LENGTH_LIMIT) n = LENGTH_LIMIT;
						if (n > dlen) n = dlen;
						if (n > ANSWER_CAP) n = ANSWER_CAP;
						for (int i = 0; i < n; i++)
							emit(KIND_DATA, descriptor_byte(sel, i),
								(i + 1 == n) || ((i + 1) % PACKET_BYTES == 0));
					end
				end else if (it.rcode == RQ_SET_CONFIGURATION && it.rtype == TYPE_STD_OUT) begin
					config_value = it.rvalue[7:0];
					emit(KIND_ACK, 8'd0, 1'b0);
				end else if (it.rcode == RQ_SET_ADDRESS) begin
					dev_addr = it.rvalue[6:0];
					dev_addr_en = 1'b1;
					emit(KIND_ACK, 8'd0, 1'b0);
				end else if (it.rcode == RQ_GET_CONFIGURATION && it.rtype == TYPE_STD_IN) begin
					emit(KIND_DATA, config_value, 1'b1);
				end else if (it.rcode == RQ_GET_STATUS) begin
					emit(KIND_DATA, 8'd0, 1'b0);
					emit(KIND_DATA, 8'd0, 1'b1);
				end else if (it.rindex == 16'd0 && it.rtype == TYPE_CLASS_IN
						&& it.rcode == RQ_HID_GET_REPORT) begin
					emit(KIND_DATA, 8'd0, 1'b0);
					emit(KIND_DATA, 8'd0, 1'b1);
				end else if (it.rindex == 16'd0 && it.rtype == TYPE_CLASS_IN
						&& it.rcode == RQ_HID_GET_IDLE) begin
					emit(KIND_DATA, 8'd0, 1'b1);
				end else if (it.rindex == 16'd0 && it.rtype == TYPE_CLASS_OUT
						&& it.rcode == RQ_HID_SET_IDLE) begin
					emit(KIND_ACK, 8'd0, 1'b0);
				end else begin
					emit(KIND_STALL, 8'd0, 1'b0);
				end
			end
			OP_BUS_RESET: config_value = 8'd0;
			OP_REPORT: begin
				if (config_value == 8'd0) begin
					emit(KIND_REFUSED, 8'd0, 1'b0);
				end else begin
					emit(KIND_REPORT, it.btn & BUTTON_MASK, 1'b0);
					emit(KIND_REPORT, it.dial, 1'b1);
				end
			end
			default: ;
		endcase
		// rows with a hand-written answer replace the computed one
		if (it.typed) begin
			fresh_answers.delete();
			emit(it.t_kind, 8'd0, 1'b0);
		end
		foreach (fresh_answers[i]) begin
			fresh_answers[i].fin = (i == fresh_answers.size() - 1);
			fresh_answers[i].addr = dev_addr;
			fresh_answers[i].aen = dev_addr_en;
			pending_answers.push_back(fresh_answers[i]);
		end
	endfunction

	function automatic item_t random_item();
		item_t it;
		int pick;
		it.op = OP_SETUP;
		it.rtype = TYPE_STD_IN;
		it.rcode = RQ_GET_DESCRIPTOR;
		it.rvalue = 16'd0;
		it.rindex = 16'd0;
		it.rlength = 16'($urandom_range(0, 64));
		it.btn = 8'($urandom);
		it.dial = 8'($urandom);
		it.typed = 1'b0;
		it.t_kind = KIND_DATA;
		pick = $urandom_range(0, 99);
		if (pick < 30) begin
			case ($urandom_range(0, 3))
				0: it.rvalue = DESC_DEVICE;
				1: it.rvalue = DESC_CONFIG;
				2: it.rvalue = DESC_HID;
				default: it.rvalue = DESC_REPORT;
			endcase
			if ($urandom_range(0, 3) == 0) it.rlength = 16'($urandom);
		end else if (pick < 38) begin
			it.rtype = TYPE_STD_OUT;
			it.rcode = RQ_SET_CONFIGURATION;
			it.rvalue = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 2));
		end else if (pick < 43) begin
			it.rtype = 8'($urandom);
			it.rcode = RQ_SET_ADDRESS;
			it.rvalue = 16'($urandom);
		end else if (pick < 50) begin
			it.rcode = RQ_GET_CONFIGURATION;
			it.rlength = 16'd1;
		end else if (pick < 55) begin
			it.rtype = 8'($urandom);
			it.rcode = RQ_GET_STATUS;
			it.rlength = 16'd2;
		end else if (pick < 62) begin
			case ($urandom_range(0, 2))
				0: begin it.rtype = TYPE_CLASS_IN; it.rcode = RQ_HID_GET_REPORT; end
				1: begin it.rtype = TYPE_CLASS_IN; it.rcode = RQ_HID_GET_IDLE; end
				default: begin it.rtype = TYPE_CLASS_OUT; it.rcode = RQ_HID_SET_IDLE; end
			endcase
		end else if (pick < 80) begin
			it.op = OP_REPORT;
		end else if (pick < 84) begin
			it.op = OP_BUS_RESET;
		end else if (pick < 92) begin
			// broken requests: bad selector, wrong direction or nonzero interface
			case ($urandom_range(0, 3))
				0: it.rvalue = 16'($urandom);
				1: begin it.rtype = 8'($urandom); it.rcode = RQ_SET_CONFIGURATION; end
				2: begin it.rtype = 8'($urandom); it.rcode = RQ_GET_CONFIGURATION; end
				default: begin
					it.rtype = TYPE_CLASS_IN;
					it.rcode = $urandom_range(0, 1) ? RQ_HID_GET_REPORT : RQ_HID_GET_IDLE;
					it.rindex = 16'($urandom);
				end
			endcase
		end else begin
			it.op = opcode_t'(2'($urandom_range(0, 3)));
			it.rtype = 8'($urandom);
			it.rcode = 8'($urandom);
			it.rvalue = 16'($urandom);
			it.rindex = 16'($urandom);
			it.rlength = 16'($urandom);
		end
		return it;
	endfunction

	// offer one transfer, hold it until accepted, then maybe leave a gap
	task automatic send_item(input item_t it);
		req_valid <= 1'b1;
		opcode <= it.op;
		request_type <= it.rtype;
		request_code <= it.rcode;
		request_value <= it.rvalue;
		request_index <= it.rindex;
		host_max_bytes <= it.rlength;
		buttons <= it.btn;
		dial_delta <= it.dial;
		cur_item <= it;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		if (!quiet && $urandom_range(0, 99) < 8) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	task automatic run_random(input int count);
		item_t it;
		int sent;
		sent = 0;
		while (sent < count) begin
			it = random_item();
			send_item(it);
			if (it.op != OP_UNUSED) sent++;
		end
	endtask

	// wait for every answer, then for work that gives none
	task automatic settle();
		req_valid <= 1'b0;
		do @(negedge clk); while (pending_answers.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic load_registers(input logic [15:0] vid, input logic [15:0] pid,
			input logic [2:0] ep);
		cfg_we <= 1'b1;
		cfg_index <= REG_VENDOR_ID;
		cfg_data <= vid;
		@(posedge clk);
		cfg_index <= REG_PRODUCT_ID;
		cfg_data <= pid;
		@(posedge clk);
		cfg_index <= REG_REPORT_ENDPOINT;
		cfg_data <= {13'd0, ep};
		@(posedge clk);
		cfg_we <= 1'b0;
		vendor_reg = vid;
		product_reg = pid;
		endpoint_reg = ep;
	endtask

	// result side: random back-pressure plus requested long hold-offs
	always @(posedge clk) begin
		if (hold_left > 0) begin
			res_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_served != hold_requests) begin
			hold_served <= hold_served + 1;
			hold_left <= HOLD_CYCLES;
			res_ready <= 1'b0;
		end else begin
			res_ready <= quiet || ($urandom_range(0, 99) >= 8);
		end
	end

	// predict on each accepted request, compare each accepted answer, watchdog
	always @(posedge clk) begin : check_side
		answer_t want;
		if (arst_n) begin
			if (req_valid && req_ready) predict_answer(cur_item);
			if (res_valid && res_ready) begin
				if (pending_answers.size() == 0) begin
					report_mismatch("result with none expected, kind", kind, 0);
				end else begin
					want = pending_answers.pop_front();
					if (kind !== want.kind) report_mismatch("kind", kind, want.kind);
					if (data_byte !== want.data) report_mismatch("data_byte", data_byte, want.data);
					if (packet_end !== want.pend) report_mismatch("packet_end", packet_end, want.pend);
					if (last !== want.fin) report_mismatch("last", last, want.fin);
					if (device_address !== want.addr)
						report_mismatch("device_address", device_address, want.addr);
					if (address_enabled !== want.aen)
						report_mismatch("address_enabled", address_enabled, want.aen);
				end
			end
			if ((req_valid && req_ready) || (res_valid && res_ready)) begin
				idle_cycles = 0;
			end else if (req_valid || pending_answers.size() != 0) begin
				idle_cycles++;
				if (idle_cycles >= WATCHDOG_LIMIT) begin
					$display("testbench: done, errors");
					$finish;
				end
			end
		end
	end

	// stimulus sequence
	initial begin
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_VENDOR_ID;
		cfg_data <= 16'd0;
		req_valid <= 1'b0;
		opcode <= OP_SETUP;
		request_type <= 8'd0;
		request_code <= 8'd0;
		request_value <= 16'd0;
		request_index <= 16'd0;
		host_max_bytes <= 16'd0;
		buttons <= 8'd0;
		dial_delta <= 8'sd0;
		cur_item <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed rows run with the registers at their reset values
		foreach (directed_rows[i]) send_item(directed_rows[i]);
		settle();

		load_registers(16'hFFFF, 16'h0000, 3'd6);
		run_random(30);
		settle();

		// long result hold-off so the request side backs up
		load_registers(16'h0000, 16'hFFFF, 3'd1);
		hold_requests++;
		run_random(30);
		settle();

		load_registers(16'($urandom), 16'($urandom), 3'($urandom_range(1, 6)));
		quiet = 1'b1;
		run_random(15);
		quiet = 1'b0;
		run_random(20);
		settle();

		if (mismatches == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule

>>> filelist.f
rtl/uhid_pkg.sv
rtl/uhid_front.sv
rtl/uhid_queue.sv
rtl/uhid_back.sv
rtl/usb_hid_control_request_handler_core.sv
rtl/uhid_checker.sv
dv/testbench.sv
